### sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the three-class sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_CLASSES_DEF = 3;
    localparam int VALUE_W         = 32;
    localparam int CLASS_W         = 2;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_CLASS = 2'd3
    } status_t;

    typedef struct packed {
        logic start;
        logic deq;
    } seq_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } seq_stat_t;

endpackage

### sv/spq_item_if.sv
// ----------------------------------------------------------------------------
// spq_item_if
// Request channel: one beat carries an enqueue or dequeue request.
// ----------------------------------------------------------------------------
interface spq_item_if;
    import spq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [CLASS_W-1:0]         queue_class;
    logic signed [VALUE_W-1:0]  item_value;

    modport source (output valid, output req_type, output queue_class,
                    output item_value, input ready);
    modport sink   (input valid, input req_type, input queue_class,
                    input item_value, output ready);
endinterface

### sv/spq_result_if.sv
// ----------------------------------------------------------------------------
// spq_result_if
// Result channel: one beat carries a value and a status.
// ----------------------------------------------------------------------------
interface spq_result_if;
    import spq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  out_value;
    logic [1:0]                 status;

    modport source (output valid, output out_value, output status, input ready);
    modport sink   (input valid, input out_value, input status, output ready);
endinterface

### sv/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/spq_seq.sv
// ----------------------------------------------------------------------------
// spq_seq
// Sequencer that walks one class's slice of the store: insertion from the
// tail for an enqueue, head removal and shift-down for a dequeue. One signed
// compare and one address adder per port are shared by every step.
// ----------------------------------------------------------------------------
module spq_seq #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_CLASSES = spq_pkg::NUM_CLASSES_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int ADDR_W      = $clog2(NUM_CLASSES * QUEUE_DEPTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spq_pkg::seq_ctrl_t                ctrl,
    input  logic [ADDR_W-1:0]                 base,
    input  logic [CNT_W-1:0]                  count,
    input  logic signed [spq_pkg::VALUE_W-1:0] value,
    output spq_pkg::seq_stat_t                stat,
    output logic signed [spq_pkg::VALUE_W-1:0] result_value,
    output logic                              mem_we,
    output logic [ADDR_W-1:0]                 mem_waddr,
    output logic [spq_pkg::VALUE_W-1:0]       mem_wdata,
    output logic                              mem_re,
    output logic [ADDR_W-1:0]                 mem_raddr,
    input  logic [spq_pkg::VALUE_W-1:0]       mem_rdata
);
    import spq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_E_TEST,
        S_E_CMP,
        S_D_HEAD,
        S_D_TEST,
        S_D_MOVE
    } state_t;

    state_t                     state_reg, state_next;
    logic [ADDR_W-1:0]          base_reg, base_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [CNT_W-1:0]           pos_reg, pos_next;
    logic signed [VALUE_W-1:0]  val_reg, val_next;
    logic signed [VALUE_W-1:0]  result_reg, result_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           roff;
    logic [CNT_W-1:0]           woff;
    logic                       rd_gt;

    assign rd_gt     = $signed(mem_rdata) > val_reg;
    assign mem_raddr = ((state_reg == S_IDLE) ? base : base_reg) + ADDR_W'(roff);
    assign mem_waddr = base_reg + ADDR_W'(woff);

    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        n_next      = n_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wdata   = val_reg;
        roff        = '0;
        woff        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    base_next   = base;
                    n_next      = count;
                    val_next    = value;
                    result_next = '0;
                    if (ctrl.deq)
                    begin
                        mem_re     = 1'b1;
                        pos_next   = CNT_W'(1);
                        state_next = S_D_HEAD;
                    end
                    else
                    begin
                        pos_next   = count;
                        state_next = S_E_TEST;
                    end
                end
            end
            S_E_TEST:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    roff       = pos_reg - CNT_W'(1);
                    state_next = S_E_CMP;
                end
            end
            S_E_CMP:
            begin
                mem_we = 1'b1;
                woff   = pos_reg;
                if (rd_gt)
                begin
                    mem_wdata  = mem_rdata;
                    pos_next   = pos_reg - CNT_W'(1);
                    state_next = S_E_TEST;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_D_HEAD:
            begin
                result_next = mem_rdata;
                state_next  = S_D_TEST;
            end
            S_D_TEST:
            begin
                if (pos_reg == n_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    roff       = pos_reg;
                    state_next = S_D_MOVE;
                end
            end
            S_D_MOVE:
            begin
                mem_we     = 1'b1;
                woff       = pos_reg - CNT_W'(1);
                mem_wdata  = mem_rdata;
                pos_next   = pos_reg + CNT_W'(1);
                state_next = S_D_TEST;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        n_reg      <= n_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        result_reg <= result_next;
    end

    assign stat.busy    = (state_reg != S_IDLE) || done_reg;
    assign stat.done    = done_reg;
    assign result_value = result_reg;

endmodule

### sv/three_class_sorted_priority_queue_unit.sv
// Class, full and empty faults give their result in the cycle after the beat.
// An enqueue walks down from the tail of its class, moving each stored value above it
// up one slot, and writes the new value where the walk stops; a dequeue reads the head
// and shifts the remaining values of the class down one slot.
// One request at a time; the next beat is taken with the result beat of the last.
// Reset clears the per-class counts and control; the store itself is not cleared.
// ----------------------------------------------------------------------------
// three_class_sorted_priority_queue_unit
// Per-class sorted queues in one shared RAM, each class kept in ascending
// order, with class checks, fill counts and a registered result beat.
// ----------------------------------------------------------------------------
module three_class_sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_CLASSES = spq_pkg::NUM_CLASSES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    spq_item_if.sink     request,
    spq_result_if.source result
);
    import spq_pkg::*;

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_CLASSES * QUEUE_DEPTH);
    localparam int DEPTH  = NUM_CLASSES * QUEUE_DEPTH;

    logic [CNT_W-1:0]           cnt_reg [NUM_CLASSES];
    logic [CNT_W-1:0]           cnt_next [NUM_CLASSES];
    logic                       out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0]  out_value_reg, out_value_next;
    status_t                    status_reg, status_next;

    logic                       accept;
    logic                       cls_ok;
    logic [CNT_W-1:0]           n_sel;
    logic [ADDR_W-1:0]          base_sel;
    seq_ctrl_t                  seq_ctrl;
    seq_stat_t                  seq_stat;
    logic signed [VALUE_W-1:0]  seq_value;

    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [VALUE_W-1:0]         mem_wdata;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [VALUE_W-1:0]         mem_rdata;

    assign request.ready = !seq_stat.busy && (!out_valid_reg || result.ready);
    assign accept        = request.valid && request.ready;

    always_comb
    begin
        cls_ok   = 1'b0;
        n_sel    = '0;
        base_sel = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (32'(request.queue_class) == c)
            begin
                cls_ok   = 1'b1;
                n_sel    = cnt_reg[c];
                base_sel = ADDR_W'(c * QUEUE_DEPTH);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        seq_ctrl.start = 1'b0;
        seq_ctrl.deq   = request.req_type == REQ_DEQ;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            cnt_next[c] = cnt_reg[c];
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (seq_stat.done)
        begin
            out_valid_next = 1'b1;
            out_value_next = seq_value;
            status_next    = ST_OK;
        end
        else if (accept)
        begin
            if (!cls_ok)
            begin
                out_valid_next = 1'b1;
                out_value_next = '1;
                status_next    = ST_BAD_CLASS;
            end
            else if (request.req_type == REQ_ENQ && n_sel == CNT_W'(QUEUE_DEPTH))
            begin
                out_valid_next = 1'b1;
                out_value_next = '1;
                status_next    = ST_FULL;
            end
            else if (request.req_type == REQ_DEQ && n_sel == '0)
            begin
                out_valid_next = 1'b1;
                out_value_next = '1;
                status_next    = ST_EMPTY;
            end
            else
            begin
                seq_ctrl.start = 1'b1;
                for (int c = 0; c < NUM_CLASSES; c++)
                begin
                    if (32'(request.queue_class) == c)
                    begin
                        cnt_next[c] = (request.req_type == REQ_DEQ)
                                      ? cnt_reg[c] - CNT_W'(1)
                                      : cnt_reg[c] + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                cnt_reg[c] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                cnt_reg[c] <= cnt_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.out_value = out_value_reg;
    assign result.status    = status_reg;

    spq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_CLASSES (NUM_CLASSES),
        .CNT_W       (CNT_W),
        .ADDR_W      (ADDR_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (seq_ctrl),
        .base         (base_sel),
        .count        (n_sel),
        .value        (request.item_value),
        .stat         (seq_stat),
        .result_value (seq_value),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    spq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

`ifndef NO_ASSERTIONS
    a_bad_class_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cls_ok |=> result.valid && result.status == ST_BAD_CLASS)
        else $error("invalid class beat not answered next cycle");

    a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        seq_stat.done |-> !out_valid_reg)
        else $error("sequencer finished while result slot held");

    a_fault_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != ST_OK |-> result.out_value == '1)
        else $error("fault result without all-ones value");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seq_ctrl.start |=> seq_stat.busy && !request.ready)
        else $error("request taken while sequencer active");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CNT_W'(QUEUE_DEPTH))
        else $error("class fill count beyond depth");
`endif

endmodule

### sim/tb_three_class_sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_three_class_sorted_priority_queue_unit
// Self-checking bench for the three-class sorted priority queue. A queue of
// requests, filled up front with directed corners and then with fill, drain
// and mixed sequences per class, feeds a bursty driver. A predictor tracks
// each class in sorted order and a monitor checks every result beat in order
// against it, while the result side stalls on its own pattern and holds off
// for long stretches.
// ----------------------------------------------------------------------------
module tb_three_class_sorted_priority_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
    localparam int NUM_CLASSES  = NUM_CLASSES_DEF;
    localparam int ITEM_GOAL    = 1150;
    localparam int STUCK_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 40;
    localparam int BAD_CLASS    = 3;
    localparam logic signed [VALUE_W-1:0] NO_VALUE = -1;

    typedef struct {
        logic                      req_type;
        logic [CLASS_W-1:0]        queue_class;
        logic signed [VALUE_W-1:0] item_value;
    } request_t;

    typedef struct {
        logic signed [VALUE_W-1:0] out_value;
        status_t                   status;
    } queue_result_t;

    logic clk;
    logic rst_n;

    spq_item_if   req_if ();
    spq_result_if res_if ();

    three_class_sorted_priority_queue_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_CLASSES (NUM_CLASSES)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if)
    );

    request_t      pending_requests[$];
    queue_result_t expected_results[$];
    request_t      next_beat;
    queue_result_t seen_result;

    logic signed [VALUE_W-1:0] sorted_vals[NUM_CLASSES][QUEUE_DEPTH];
    int sorted_fill[NUM_CLASSES];
    int gen_fill[NUM_CLASSES];

    int beats_in;
    int results_checked;
    int mismatches;
    int n_enq_ok;
    int n_deq_ok;
    int n_full;
    int n_empty;
    int n_bad_class;
    int burst_left;
    int gap_left;
    int hold_left;
    int holds_done;
    int stall_phase;
    int stall_mode;
    int stuck_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic queue_result_t predict_sorted_queue(request_t r);
        queue_result_t res;
        int n;
        int pos;
        res.out_value = NO_VALUE;
        if (r.queue_class >= NUM_CLASSES)
        begin
            res.status = ST_BAD_CLASS;
            n_bad_class++;
            return res;
        end
        n = sorted_fill[r.queue_class];
        if (r.req_type == REQ_ENQ)
        begin
            if (n >= QUEUE_DEPTH)
            begin
                res.status = ST_FULL;
                n_full++;
            end
            else
            begin
                pos = 0;
                while (pos < n && sorted_vals[r.queue_class][pos] <= r.item_value)
                    pos++;
                for (int i = n; i > pos; i--)
                    sorted_vals[r.queue_class][i] = sorted_vals[r.queue_class][i-1];
                sorted_vals[r.queue_class][pos] = r.item_value;
                sorted_fill[r.queue_class] = n + 1;
                res.out_value = '0;
                res.status = ST_OK;
                n_enq_ok++;
            end
        end
        else if (n == 0)
        begin
            res.status = ST_EMPTY;
            n_empty++;
        end
        else
        begin
            res.out_value = sorted_vals[r.queue_class][0];
            for (int i = 1; i < n; i++)
                sorted_vals[r.queue_class][i-1] = sorted_vals[r.queue_class][i];
            sorted_fill[r.queue_class] = n - 1;
            res.status = ST_OK;
            n_deq_ok++;
        end
        return res;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = $signed($urandom_range(0, 16)) - 8;
            3:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = '0;
                    default: v = NO_VALUE;
                endcase
            end
            4: v = 32'sh7fff_ffff - $signed($urandom_range(0, 3));
            default: v = 32'sh8000_0000 + $signed($urandom_range(0, 3));
        endcase
        return v;
    endfunction

    task automatic add_request(logic req, int cls, logic signed [VALUE_W-1:0] val);
        request_t r;
        r.req_type = req;
        r.queue_class = cls[CLASS_W-1:0];
        r.item_value = val;
        pending_requests.push_back(r);
        if (cls < NUM_CLASSES)
        begin
            if (req == REQ_ENQ && gen_fill[cls] < QUEUE_DEPTH)
                gen_fill[cls]++;
            else if (req == REQ_DEQ && gen_fill[cls] > 0)
                gen_fill[cls]--;
        end
    endtask

    // driver: bursts of beats with random gaps, held until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                next_beat.req_type = req_if.req_type;
                next_beat.queue_class = req_if.queue_class;
                next_beat.item_value = req_if.item_value;
                expected_results.push_back(predict_sorted_queue(next_beat));
                beats_in++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (gap_left != 0)
                begin
                    req_if.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_beat = pending_requests.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.req_type <= next_beat.req_type;
                    req_if.queue_class <= next_beat.queue_class;
                    req_if.item_value <= next_beat.item_value;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // result side: stall pattern switching at each wrap of its phase counter, plus long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            hold_left <= 0;
            holds_done <= 0;
            stall_phase <= 0;
            stall_mode <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 64;
            if (stall_phase == 63)
                stall_mode <= $urandom_range(0, 3);
            if (hold_left != 0)
            begin
                res_if.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if ((holds_done == 0 && beats_in >= 300) ||
                     (holds_done == 1 && beats_in >= 850))
            begin
                res_if.ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                holds_done <= holds_done + 1;
            end
            else
            begin
                case (stall_mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= 1'($urandom_range(0, 1));
                    2: res_if.ready <= (stall_phase % 4) == 0;
                    default: res_if.ready <= $urandom_range(0, 4) != 0;
                endcase
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result beat: value %0d status %0d",
                             res_if.out_value, res_if.status);
                mismatches++;
            end
            else
            begin
                seen_result = expected_results.pop_front();
                if (seen_result.out_value !== res_if.out_value ||
                    seen_result.status !== res_if.status)
                begin
                    if (mismatches < 10)
                        $display({"result %0d: expected value %0d status %0d, ",
                                  "got value %0d status %0d"},
                                 results_checked, seen_result.out_value,
                                 seen_result.status, res_if.out_value, res_if.status);
                    mismatches++;
                end
                results_checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        logic signed [VALUE_W-1:0] corner_vals[16];
        int cls;
        int run_len;

        corner_vals = '{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 5, 5, -5, 32'sh7fff_ffff,
                        32'sh8000_0000, 1, 1, -2, 100, 0, -1, 3};
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_ENQ;
        req_if.queue_class = '0;
        req_if.item_value = '0;
        res_if.ready = 1'b0;
        beats_in = 0;
        results_checked = 0;
        mismatches = 0;
        stuck_cycles = 0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            sorted_fill[c] = 0;
            gen_fill[c] = 0;
        end

        for (int i = 0; i < 16; i++)
            add_request(REQ_ENQ, 2, corner_vals[i]);
        add_request(REQ_ENQ, 2, 7);
        add_request(REQ_DEQ, 1, $urandom);
        add_request(REQ_ENQ, BAD_CLASS, 9);
        add_request(REQ_DEQ, BAD_CLASS, $urandom);
        add_request(REQ_DEQ, 2, 0);
        add_request(REQ_DEQ, 2, 0);
        add_request(REQ_ENQ, 0, 42);

        while (pending_requests.size() < ITEM_GOAL)
        begin
            cls = $urandom_range(0, NUM_CLASSES - 1);
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    while (gen_fill[cls] < QUEUE_DEPTH)
                        add_request(REQ_ENQ, cls, pick_value());
                    repeat ($urandom_range(1, 2))
                        add_request(REQ_ENQ, cls, pick_value());
                end
                3, 4, 5:
                begin
                    while (gen_fill[cls] > 0)
                        add_request(REQ_DEQ, cls, $urandom);
                    repeat ($urandom_range(1, 2))
                        add_request(REQ_DEQ, cls, $urandom);
                end
                6, 7, 8:
                begin
                    run_len = $urandom_range(10, 40);
                    repeat (run_len)
                    begin
                        cls = $urandom_range(0, NUM_CLASSES - 1);
                        if ($urandom_range(0, 1) == 0)
                            add_request(REQ_ENQ, cls, pick_value());
                        else
                            add_request(REQ_DEQ, cls, $urandom);
                    end
                end
                default:
                begin
                    repeat ($urandom_range(1, 3))
                        add_request(1'($urandom_range(0, 1)), $urandom_range(0, 3),
                                    $urandom);
                end
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || req_if.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display({"Covered %0d requests: %0d enqueued, %0d dequeued, ",
                  "%0d full, %0d empty, %0d bad class."},
                 beats_in, n_enq_ok, n_deq_ok, n_full, n_empty, n_bad_class);
        $display("Checked %0d result beats, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
